[rtl/core/stns_pkg.sv]
// Shared types and constants for the sorted-table nearest search block.
// Used by the request/response interfaces, controller, datapath and top level.
`default_nettype none

package stns_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int DIFF_W      = VALUE_WIDTH + 1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_FIRST,
		ST_CHK_LAST,
		ST_SEARCH,
		ST_READ_UP,
		ST_READ_LO,
		ST_PICK,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		AS_ZERO,
		AS_LAST,
		AS_MID,
		AS_UP,
		AS_LO
	} addr_sel_t;

	typedef enum logic [1:0] {
		RS_FIRST,
		RS_LAST,
		RS_PICK
	} res_sel_t;

	typedef struct packed {
		logic      in_ready;
		logic      cap_val;
		addr_sel_t addr_sel;
		logic      range_init;
		logic      range_upd;
		logic      ld_up;
		logic      ld_lo;
		logic      res_ld;
		res_sel_t  res_sel;
		logic      out_ld;
	} cmd_t;

	typedef struct packed {
		logic query_go;
		logic rd_lt_val;
		logic val_lt_rd;
		logic range_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/stns_req_if.sv]
// Request channel: valid/ready handshake carrying one write or query word.
// Depends on stns_pkg for field widths.
`default_nettype none

interface stns_req_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   req_type;
	logic [7:0]                             entry_index;
	logic signed [stns_pkg::VALUE_WIDTH-1:0] item_value;

	modport source (output valid, req_type, entry_index, item_value, input ready);
	modport sink   (input valid, req_type, entry_index, item_value, output ready);
endinterface

`default_nettype wire

[rtl/core/stns_rsp_if.sv]
// Response channel: valid/ready handshake carrying one nearest-entry word.
// Depends on stns_pkg for field widths.
`default_nettype none

interface stns_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic [7:0]                             nearest_index;
	logic signed [stns_pkg::VALUE_WIDTH-1:0] nearest_value;

	modport source (output valid, nearest_index, nearest_value, input ready);
	modport sink   (input valid, nearest_index, nearest_value, output ready);
endinterface

`default_nettype wire

[rtl/core/stns_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module stns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

[rtl/core/stns_ctrl.sv]
// Controller state machine for the nearest search: sequences table reads,
// the binary search steps and result delivery. Depends on stns_pkg.
`default_nettype none

module stns_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire stns_pkg::sts_t  sts,
	output stns_pkg::cmd_t       cmd
);

	stns_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stns_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stns_pkg::ST_IDLE: begin
				if (sts.query_go) state_d = stns_pkg::ST_CHK_FIRST;
			end
			stns_pkg::ST_CHK_FIRST: begin
				state_d = sts.rd_lt_val ? stns_pkg::ST_CHK_LAST : stns_pkg::ST_FINISH;
			end
			stns_pkg::ST_CHK_LAST: begin
				state_d = sts.val_lt_rd ? stns_pkg::ST_SEARCH : stns_pkg::ST_FINISH;
			end
			stns_pkg::ST_SEARCH: begin
				if (sts.range_done) state_d = stns_pkg::ST_READ_UP;
			end
			stns_pkg::ST_READ_UP: state_d = stns_pkg::ST_READ_LO;
			stns_pkg::ST_READ_LO: state_d = stns_pkg::ST_PICK;
			stns_pkg::ST_PICK:    state_d = stns_pkg::ST_FINISH;
			stns_pkg::ST_FINISH: begin
				if (sts.out_free) state_d = stns_pkg::ST_IDLE;
			end
			default: state_d = stns_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.addr_sel = stns_pkg::AS_ZERO;
		cmd.res_sel  = stns_pkg::RS_FIRST;
		unique case (state_q)
			stns_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.cap_val  = sts.query_go;
			end
			stns_pkg::ST_CHK_FIRST: begin
				// at or below entry 0: answer entry 0, else look at the last entry
				cmd.addr_sel = stns_pkg::AS_LAST;
				cmd.res_ld   = !sts.rd_lt_val;
				cmd.res_sel  = stns_pkg::RS_FIRST;
			end
			stns_pkg::ST_CHK_LAST: begin
				cmd.addr_sel   = stns_pkg::AS_MID;
				cmd.range_init = 1'b1;
				cmd.range_upd  = sts.val_lt_rd;
				cmd.res_ld     = !sts.val_lt_rd;
				cmd.res_sel    = stns_pkg::RS_LAST;
			end
			stns_pkg::ST_SEARCH: begin
				cmd.range_upd = 1'b1;
				cmd.addr_sel  = sts.range_done ? stns_pkg::AS_UP : stns_pkg::AS_MID;
			end
			stns_pkg::ST_READ_UP: begin
				cmd.ld_up    = 1'b1;
				cmd.addr_sel = stns_pkg::AS_LO;
			end
			stns_pkg::ST_READ_LO: begin
				cmd.ld_lo = 1'b1;
			end
			stns_pkg::ST_PICK: begin
				cmd.res_ld  = 1'b1;
				cmd.res_sel = stns_pkg::RS_PICK;
			end
			stns_pkg::ST_FINISH: begin
				cmd.out_ld = sts.out_free;
			end
			default: begin
				cmd.in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/stns_dp.sv]
// Datapath for the nearest search: table RAM, search range registers,
// distance comparison and the output register. Depends on stns_pkg, stns_ram.
`default_nettype none

module stns_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire stns_pkg::cmd_t                         cmd,
	output stns_pkg::sts_t                              sts,
	input  wire logic                                   cfg_we,
	input  wire logic [7:0]                             cfg_wdata,
	input  wire logic                                   req_valid,
	input  wire logic                                   req_type,
	input  wire logic [7:0]                             entry_index,
	input  wire logic signed [stns_pkg::VALUE_WIDTH-1:0] item_value,
	output logic                                        rsp_valid,
	input  wire logic                                   rsp_ready,
	output logic [7:0]                                  nearest_index,
	output logic signed [stns_pkg::VALUE_WIDTH-1:0]     nearest_value
);

	localparam int VW = stns_pkg::VALUE_WIDTH;
	localparam int IW = stns_pkg::IDX_W;
	localparam int DW = stns_pkg::DIFF_W;

	logic [IW-1:0]          last_q;
	logic                   rsp_valid_q;

	logic signed [VW-1:0]   val_q;
	logic [IW-1:0]          lo_q, hi_q, mid_q;
	logic signed [VW-1:0]   up_q, lo_val_q;
	logic signed [DW-1:0]   up_diff_q, dn_diff_q;
	logic [IW-1:0]          res_idx_q;
	logic signed [VW-1:0]   res_val_q;
	logic [IW-1:0]          out_idx_q;
	logic signed [VW-1:0]   out_val_q;

	logic [VW-1:0]          ram_rd;
	logic signed [VW-1:0]   rd_data;
	logic [IW-1:0]          rd_addr;
	logic                   wr_en;
	logic [IW-1:0]          nlo, nhi, mid_n;
	logic                   pick_up;

	assign rd_data = $signed(ram_rd);
	assign wr_en   = req_valid && cmd.in_ready && (req_type == stns_pkg::REQ_WRITE);

	stns_ram #(
		.WIDTH (VW),
		.DEPTH (stns_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (entry_index[IW-1:0]),
		.wr_data (item_value),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	// next search range: either the initial full span or one halving step
	always_comb begin
		if (cmd.range_init) begin
			nlo = '0;
			nhi = last_q;
		end else if (sts.val_lt_rd) begin
			nlo = lo_q;
			nhi = mid_q - IW'(1);
		end else begin
			nlo = mid_q;
			nhi = hi_q;
		end
		mid_n = nhi - ((nhi - nlo) >> 1);
	end

	always_comb begin
		unique case (cmd.addr_sel)
			stns_pkg::AS_ZERO: rd_addr = '0;
			stns_pkg::AS_LAST: rd_addr = last_q;
			stns_pkg::AS_MID:  rd_addr = mid_n;
			stns_pkg::AS_UP:   rd_addr = nlo + IW'(1);
			stns_pkg::AS_LO:   rd_addr = lo_q;
			default:           rd_addr = '0;
		endcase
	end

	always_comb begin
		sts.query_go   = req_valid && (req_type == stns_pkg::REQ_QUERY);
		sts.rd_lt_val  = rd_data < val_q;
		sts.val_lt_rd  = val_q < rd_data;
		sts.range_done = (nlo == nhi);
		sts.out_free   = !rsp_valid_q || rsp_ready;
	end

	// upper neighbor wins only when strictly closer; ties go to the lower entry
	assign pick_up = (lo_q != last_q) && (up_diff_q < dn_diff_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) last_q <= cfg_wdata[IW-1:0];
			if (cmd.out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_val) val_q <= item_value;
		if (cmd.range_upd) begin
			lo_q  <= nlo;
			hi_q  <= nhi;
			mid_q <= mid_n;
		end
		if (cmd.ld_up) up_q <= rd_data;
		if (cmd.ld_lo) begin
			lo_val_q  <= rd_data;
			up_diff_q <= $signed({up_q[VW-1], up_q}) - $signed({val_q[VW-1], val_q});
			dn_diff_q <= $signed({val_q[VW-1], val_q}) - $signed({rd_data[VW-1], rd_data});
		end
		if (cmd.res_ld) begin
			unique case (cmd.res_sel)
				stns_pkg::RS_FIRST: begin
					res_idx_q <= '0;
					res_val_q <= rd_data;
				end
				stns_pkg::RS_LAST: begin
					res_idx_q <= last_q;
					res_val_q <= rd_data;
				end
				stns_pkg::RS_PICK: begin
					res_idx_q <= pick_up ? lo_q + IW'(1) : lo_q;
					res_val_q <= pick_up ? up_q : lo_val_q;
				end
				default: begin
					res_idx_q <= '0;
					res_val_q <= rd_data;
				end
			endcase
		end
		if (cmd.out_ld) begin
			out_idx_q <= res_idx_q;
			out_val_q <= res_val_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign nearest_index = 8'(out_idx_q);
	assign nearest_value = out_val_q;

endmodule

`default_nettype wire

[rtl/core/sorted_table_nearest_search.sv]
// Top level of the sorted-table nearest search: controller plus datapath.
// Depends on stns_pkg, stns_req_if, stns_rsp_if, stns_ctrl, stns_dp.
`default_nettype none

// A write word stores one table entry and gives no response.
// A query word returns the index and value of the entry nearest the query.
// The table sits in a RAM with one registered read port, and every search step
// waits for its read. A query that falls at or below entry 0 or at or above the
// last entry is answered without a search; otherwise it takes k halving steps,
// at most ceil(log2(last+1)), which is 8 for a full table. Write words are taken
// while a response waits on the output; the next query may start then too and
// holds its answer until the output register frees up. The table has no reset:
// read only written entries.

module sorted_table_nearest_search (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	stns_req_if.sink        req,
	stns_rsp_if.source      rsp
);

	stns_pkg::cmd_t cmd;
	stns_pkg::sts_t sts;

	assign req.ready = cmd.in_ready;

	stns_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	stns_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_valid     (req.valid),
		.req_type      (req.req_type),
		.entry_index   (req.entry_index),
		.item_value    (req.item_value),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.nearest_index (rsp.nearest_index),
		.nearest_value (rsp.nearest_value)
	);

endmodule

`default_nettype wire
